### src/mdag_pkg.sv
// ----------------------------------------------------------------------------
// mdag_pkg: shared types and codes of the array address generator
// Item kinds, controller states and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package mdag_pkg;

	// item kinds
	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_DIM = 2'd1;
	localparam logic [1:0] KIND_IDX = 2'd2;

	// multiply sequence steps
	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_LH = 2'd1;
	localparam logic [1:0] STEP_HL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOOKUP,
		ST_MUL,
		ST_OFFSET,
		ST_SCALE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       cap;      // capture an input beat
		logic       desc_wr;  // write descriptor header
		logic       dim_wr;   // write dimension bounds
		logic       rd;       // read descriptor and bounds
		logic       lookup;   // form extent and index difference
		logic       mul;      // one step of the 64-bit multiply
		logic [1:0] step;
		logic       off_upd;  // fold product into running offset
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic       aid_ok;
		logic       dim_ok;
		logic       last;
	} status_t;

endpackage

### src/mdag_dp.sv
// ----------------------------------------------------------------------------
// mdag_dp: datapath of the array address generator
// Input capture, descriptor and bounds memories, running offset and a
// shared 32x32 multiplier that builds 64-bit products in three steps.
// ----------------------------------------------------------------------------
module mdag_dp import mdag_pkg::*; #(
	parameter int MAX_ARRAYS = 16,
	parameter int MAX_DIMS   = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [1:0]          kind,
	input  logic [3:0]          array_id,
	input  logic [3:0]          dim_number,
	input  logic [31:0]         base_address,
	input  logic [15:0]         element_size,
	input  logic [3:0]          dim_count,
	input  logic signed [31:0]  lower_bound,
	input  logic signed [31:0]  upper_bound,
	input  logic signed [31:0]  index_value,
	output logic [3:0]          result_array,
	output logic [63:0]         element_address
);

	localparam int AW     = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
	localparam int NSLOT  = MAX_ARRAYS * MAX_DIMS;
	localparam int SW     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int DESC_W = 52;

	// captured beat
	logic [1:0]  kind_q;
	logic [3:0]  aid_q;
	logic [3:0]  dnum_q;
	logic [31:0] base_in_q;
	logic [15:0] es_in_q;
	logic [3:0]  dc_in_q;
	logic [31:0] lo_in_q;
	logic [31:0] hi_in_q;
	logic [31:0] idx_q;

	// memories and read registers
	logic [DESC_W-1:0] desc_mem [MAX_ARRAYS];
	logic [63:0]       dim_mem  [NSLOT];
	logic [DESC_W-1:0] desc_rd_q;
	logic [63:0]       dim_rd_q;

	// query state
	logic [63:0] run_off_q;
	logic [3:0]  next_dim_q;
	logic [63:0] diff_q;
	logic        last_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;

	logic [3:0]    dc_fix;
	logic [3:0]    d_cur;
	logic [SW-1:0] wr_slot;
	logic [SW-1:0] rd_slot;
	logic [AW-1:0] aid_idx;
	logic [31:0]   rd_base;
	logic [15:0]   rd_es;
	logic [3:0]    rd_dims;
	logic [63:0]   lo64;
	logic [63:0]   hi64;
	logic [63:0]   idx64;
	logic [63:0]   extent;
	logic [63:0]   diff;
	logic          last;
	logic [31:0]   mul_x;
	logic [31:0]   mul_y;
	logic [63:0]   prod;
	logic [63:0]   sum;

	// capture of an accepted beat
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q    <= kind;
			aid_q     <= array_id;
			dnum_q    <= dim_number;
			base_in_q <= base_address;
			es_in_q   <= element_size;
			dc_in_q   <= dim_count;
			lo_in_q   <= lower_bound;
			hi_in_q   <= upper_bound;
			idx_q     <= index_value;
		end
	end

	// decode of the captured beat
	always_comb begin
		if (dc_in_q == 4'd0)
			dc_fix = 4'd1;
		else if (32'(dc_in_q) > MAX_DIMS)
			dc_fix = 4'(MAX_DIMS);
		else
			dc_fix = dc_in_q;
		d_cur   = (32'(next_dim_q) >= MAX_DIMS) ? 4'(MAX_DIMS - 1) : next_dim_q;
		aid_idx = AW'(aid_q);
		wr_slot = SW'(32'(aid_q) * MAX_DIMS + 32'(dnum_q));
		rd_slot = SW'(32'(aid_q) * MAX_DIMS + 32'(d_cur));
	end

	assign status.kind   = kind_q;
	assign status.aid_ok = (32'(aid_q) < MAX_ARRAYS);
	assign status.dim_ok = (32'(dnum_q) < MAX_DIMS);
	assign status.last   = last_q;

	// descriptor memory
	always_ff @(posedge clk) begin
		if (cmd.desc_wr)
			desc_mem[aid_idx] <= {dc_fix, es_in_q, base_in_q};
		if (cmd.rd)
			desc_rd_q <= desc_mem[aid_idx];
	end

	// bounds memory: {upper, lower}
	always_ff @(posedge clk) begin
		if (cmd.dim_wr)
			dim_mem[wr_slot] <= {hi_in_q, lo_in_q};
		if (cmd.rd)
			dim_rd_q <= dim_mem[rd_slot];
	end

	// extent, index difference and last-dimension test
	always_comb begin
		rd_base = desc_rd_q[31:0];
		rd_es   = desc_rd_q[47:32];
		rd_dims = desc_rd_q[51:48];
		lo64    = {{32{dim_rd_q[31]}}, dim_rd_q[31:0]};
		hi64    = {{32{dim_rd_q[63]}}, dim_rd_q[63:32]};
		idx64   = {{32{idx_q[31]}}, idx_q};
		extent  = hi64 - lo64 + 64'd1;
		diff    = idx64 - lo64;
		last    = ({1'b0, d_cur} + 5'd1) >= {1'b0, rd_dims};
	end

	// shared multiplier, low 64 bits of a 64x64 product over three steps
	always_comb begin
		unique case (cmd.step)
			STEP_LL: begin mul_x = a_q[31:0];  mul_y = b_q[31:0];  end
			STEP_LH: begin mul_x = a_q[31:0];  mul_y = b_q[63:32]; end
			STEP_HL: begin mul_x = a_q[63:32]; mul_y = b_q[31:0];  end
			default: begin mul_x = a_q[63:32]; mul_y = b_q[31:0];  end
		endcase
		prod = 64'(mul_x) * 64'(mul_y);
		sum  = acc_q + diff_q;
	end

	// operand, accumulator and offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_off_q  <= '0;
			next_dim_q <= '0;
		end else if (cmd.off_upd) begin
			if (last_q) begin
				run_off_q  <= '0;
				next_dim_q <= '0;
			end else begin
				run_off_q  <= sum;
				next_dim_q <= d_cur + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			a_q    <= run_off_q;
			b_q    <= extent;
			diff_q <= diff;
			last_q <= last;
		end else if (cmd.off_upd) begin
			a_q <= sum;
			b_q <= {48'd0, rd_es};
		end
		if (cmd.mul) begin
			if (cmd.step == STEP_LL)
				acc_q <= prod;
			else
				acc_q <= acc_q + {prod[31:0], 32'd0};
		end
	end

	// result, valid in the emit cycle
	assign result_array    = aid_q;
	assign element_address = {32'd0, rd_base} + acc_q;

	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(next_dim_q) < MAX_DIMS)
		else $error("next dimension beyond table");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.off_upd && last_q) |=> (run_off_q == 64'd0 && next_dim_q == 4'd0))
		else $error("query state not cleared after last dimension");
	a_no_cap_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cap && (cmd.rd || cmd.mul || cmd.lookup)))
		else $error("capture during query work");

endmodule

### src/mdag_ctrl.sv
// ----------------------------------------------------------------------------
// mdag_ctrl: controller of the array address generator
// Sequences table writes, the lookup, the two three-step multiplies and
// the result beat.
// ----------------------------------------------------------------------------
module mdag_ctrl import mdag_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    done,
	output cmd_t    cmd,
	input  status_t status
);

	state_t     state_q, state_d;
	logic [1:0] step_q, step_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_LL;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		step_d  = STEP_LL;
		cmd     = '0;
		cmd.step = step_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.cap = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				if (status.aid_ok) begin
					unique case (status.kind)
						KIND_HDR: cmd.desc_wr = 1'b1;
						KIND_DIM: cmd.dim_wr = status.dim_ok;
						KIND_IDX: begin
							cmd.rd  = 1'b1;
							state_d = ST_LOOKUP;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				if (step_q == STEP_HL)
					state_d = ST_OFFSET;
				else
					step_d = step_q + 2'd1;
			end
			ST_OFFSET: begin
				cmd.off_upd = 1'b1;
				state_d     = status.last ? ST_SCALE : ST_IDLE;
			end
			ST_SCALE: begin
				cmd.mul = 1'b1;
				if (step_q == STEP_HL)
					state_d = ST_EMIT;
				else
					step_d = step_q + 2'd1;
			end
			ST_EMIT: begin
				busy    = 1'b0;
				done    = 1'b1;
				state_d = ST_IDLE;
				if (start) begin
					cmd.cap = 1'b1;
					state_d = ST_DECODE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_emit_after_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> $past(state_q == ST_SCALE && step_q == STEP_HL))
		else $error("result beat without a finished scale");
	a_offset_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OFFSET) |-> $past(state_q == ST_MUL && step_q == STEP_HL))
		else $error("offset update without a finished multiply");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.desc_wr && cmd.dim_wr))
		else $error("two table writes at once");

endmodule

### src/multidim_array_address_generator.sv
// Header and bounds beats are written in the decode state after acceptance; an index
// beat that is not the last dimension frees the block after lookup, multiply and
// offset, while the last dimension also runs the scale multiply and gives its done
// beat in the emit state. No new beat is taken while busy; the shared 32x32
// multiplier takes three steps per 64-bit product (one for the offset, one for scale).
// Reset clears the controller and the running offset; tables are unset.
// ----------------------------------------------------------------------------
// multidim_array_address_generator: row-major element address generator
// Holds array descriptors and bounds and turns index beats, one dimension
// at a time, into byte addresses base + offset * element size.
// ----------------------------------------------------------------------------
module multidim_array_address_generator import mdag_pkg::*; #(
	parameter int MAX_ARRAYS = 16,
	parameter int MAX_DIMS   = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  logic [1:0]          kind,
	input  logic [3:0]          array_id,
	input  logic [3:0]          dim_number,
	input  logic [31:0]         base_address,
	input  logic [15:0]         element_size,
	input  logic [3:0]          dim_count,
	input  logic signed [31:0]  lower_bound,
	input  logic signed [31:0]  upper_bound,
	input  logic signed [31:0]  index_value,
	output logic [3:0]          result_array,
	output logic [63:0]         element_address
);

	cmd_t    cmd;
	status_t status;

	// sequencing
	mdag_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	// tables and arithmetic
	mdag_dp #(
		.MAX_ARRAYS (MAX_ARRAYS),
		.MAX_DIMS   (MAX_DIMS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.kind            (kind),
		.array_id        (array_id),
		.dim_number      (dim_number),
		.base_address    (base_address),
		.element_size    (element_size),
		.dim_count       (dim_count),
		.lower_bound     (lower_bound),
		.upper_bound     (upper_bound),
		.index_value     (index_value),
		.result_array    (result_array),
		.element_address (element_address)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not make the block busy");

endmodule
